[rtl/wav_header_parser_top_macros.svh]
`ifndef WAV_HEADER_PARSER_TOP_MACROS_SVH
`define WAV_HEADER_PARSER_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off while in reset.
`define WHP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising edge, off while in reset.
`define WHP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/wav_hdr_pkg.sv]
package wav_hdr_pkg;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_EOF  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_HDR = 2'd1;
  localparam logic [1:0] ST_BAD_FMT = 2'd2;
  localparam logic [1:0] ST_REJECT  = 2'd3;

  localparam logic [2:0] PH_RIFF  = 3'd0;
  localparam logic [2:0] PH_CHUNK = 3'd1;
  localparam logic [2:0] PH_FMT   = 3'd2;
  localparam logic [2:0] PH_SKIP  = 3'd3;
  localparam logic [2:0] PH_DONE  = 3'd4;

  localparam logic [31:0] FMT_MIN_LEN = 32'd16;
  localparam logic [31:0] ID_FMT      = 32'h2074_6d66;
  localparam logic [31:0] ID_DATA     = 32'h6174_6164;

  typedef struct packed {
    logic       opcode;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        stereo;
    logic [31:0] rate_hz;
    logic [31:0] byte_rate;
    logic [31:0] data_start;
    logic [31:0] data_size;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_push_t;

  // Expected byte of the "RIFF" <size> "WAVE" header at a given position
  function automatic logic [7:0] riff_expect(input logic [3:0] pos);
    logic [7:0] b;
    case (pos)
      4'd0:    b = 8'h52;
      4'd1:    b = 8'h49;
      4'd2:    b = 8'h46;
      4'd3:    b = 8'h46;
      4'd8:    b = 8'h57;
      4'd9:    b = 8'h41;
      4'd10:   b = 8'h56;
      4'd11:   b = 8'h45;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic out_item_t make_fail(input logic [1:0] status);
    out_item_t r;
    r        = '0;
    r.status = status;
    return r;
  endfunction

  function automatic out_item_t make_final(
    input logic [15:0] fmt_code,
    input logic [15:0] chans,
    input logic [31:0] rate,
    input logic [15:0] bits,
    input logic [31:0] file_len,
    input logic [31:0] start,
    input logic [31:0] len
  );
    out_item_t   r;
    logic [31:0] room;
    room = file_len - start;
    if (fmt_code != 16'd1 || bits != 16'd16 || (chans != 16'd1 && chans != 16'd2) ||
        rate == 32'd0 || len == 32'd0) begin
      r = make_fail(ST_REJECT);
    end else begin
      r.status      = ST_OK;
      r.stereo      = (chans == 16'd2);
      r.rate_hz     = rate;
      // channels is 1 or 2 here, so the product is a shift
      r.byte_rate   = (chans == 16'd2) ? {rate[29:0], 2'b00} : {rate[30:0], 1'b0};
      r.data_start  = start;
      r.data_size   = (len < room) ? len : room;
    end
    return r;
  endfunction

endpackage

[rtl/wav_header_parser_top.sv]
// Channel | Direction | Handshake                  | Carries
// in_     | input     | in_valid / in_stall        | in_item: opcode, byte_value
// out_    | output    | out_valid / out_stall      | out_item: status .. data_size
// cfg_    | input     | cfg_valid / cfg_ready      | cfg_data: file_length
//
// One byte is taken every cycle while in_stall is low; each byte updates the parser state
// registers in a single pass, and that state update loop sets the one-item-per-cycle rate.
// A result is registered in the output register, or in the skid entry behind a stalled one.
// Synchronous reset returns the parser to the RIFF header phase and clears file_length.
// The result side has an output register and a skid entry; in_stall rises only while
// both hold a result, so a stalled result does not hold up the byte stream by itself.
`include "wav_header_parser_top_macros.svh"

module wav_header_parser_top (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  wav_hdr_pkg::in_item_t  in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output wav_hdr_pkg::out_item_t out_item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [31:0]            cfg_data
);
  import wav_hdr_pkg::*;

  logic [31:0] file_length_r;
  logic        in_fire;
  logic        q_full;
  res_push_t   res;
  logic        fail_fields_zero;
  logic        ok_rates_match;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign in_fire   = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_length_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      file_length_r <= cfg_data;
    end
  end

  wav_hdr_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .in_item     (in_item),
    .file_length (file_length_r),
    .res         (res)
  );

  wav_hdr_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  assign fail_fields_zero = out_item.stereo == 1'b0 && out_item.rate_hz == 32'd0 &&
                            out_item.byte_rate == 32'd0 && out_item.data_start == 32'd0 &&
                            out_item.data_size == 32'd0;
  assign ok_rates_match   = out_item.rate_hz != 32'd0 &&
                            (out_item.byte_rate == {out_item.rate_hz[30:0], 1'b0} ||
                             out_item.byte_rate == {out_item.rate_hz[29:0], 2'b00});

  `WHP_ASSERT_NOW(a_stall_needs_result, clk, rst_n, in_stall, out_valid, "input stalled with no result waiting")
  `WHP_ASSERT_NOW(a_fail_zero, clk, rst_n, out_valid && out_item.status != ST_OK, fail_fields_zero, "failed result carries nonzero fields")
  `WHP_ASSERT_NOW(a_ok_rate, clk, rst_n, out_valid && out_item.status == ST_OK, ok_rates_match, "accepted result with inconsistent rates")
  `WHP_ASSERT_NEXT(a_skid_cause, clk, rst_n, !in_stall && !(out_valid && out_stall), !in_stall, "skid filled without a stalled result")

endmodule

[rtl/wav_hdr_core.sv]
module wav_hdr_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_fire,
  input  wav_hdr_pkg::in_item_t in_item,
  input  logic [31:0]           file_length,
  output wav_hdr_pkg::res_push_t res
);
  import wav_hdr_pkg::*;

  logic [2:0]  phase_r,  phase_nxt;
  logic [31:0] offset_r, offset_nxt;
  logic [3:0]  count_r,  count_nxt;
  logic [63:0] shift_r,  shift_nxt;
  logic [32:0] skip_r,   skip_nxt;
  logic [15:0] fmt_r,    fmt_nxt;
  logic [15:0] chans_r,  chans_nxt;
  logic [31:0] rate_r,   rate_nxt;
  logic [15:0] bits_r,   bits_nxt;
  logic        riff_ok_r, riff_ok_nxt;

  logic [7:0]  b;
  logic [63:0] shift_in;
  logic [31:0] hdr_len;
  logic [31:0] fmt_len;
  logic [32:0] chunk_skip;
  logic [32:0] fmt_skip;
  logic [32:0] skip_dec;

  assign b          = in_item.byte_value;
  assign shift_in   = {b, shift_r[63:8]};
  assign hdr_len    = shift_in[63:32];
  assign fmt_len    = shift_r[63:32];
  assign chunk_skip = {1'b0, hdr_len} + {32'd0, hdr_len[0]};
  assign fmt_skip   = (fmt_len > FMT_MIN_LEN) ?
                      ({1'b0, fmt_len - FMT_MIN_LEN} + {32'd0, fmt_len[0]}) : 33'd0;
  assign skip_dec   = (skip_r != 33'd0) ? (skip_r - 33'd1) : skip_r;

  always_comb begin
    phase_nxt   = phase_r;
    offset_nxt  = offset_r;
    count_nxt   = count_r;
    shift_nxt   = shift_r;
    skip_nxt    = skip_r;
    fmt_nxt     = fmt_r;
    chans_nxt   = chans_r;
    rate_nxt    = rate_r;
    bits_nxt    = bits_r;
    riff_ok_nxt = riff_ok_r;
    res         = '0;

    if (in_fire) begin
      if (in_item.opcode == OP_EOF) begin
        case (phase_r)
          PH_RIFF: res = '{valid: 1'b1, item: make_fail(ST_BAD_HDR)};
          PH_FMT:  res = '{valid: 1'b1, item: make_fail(ST_BAD_FMT)};
          PH_DONE: res = '0;
          // no data chunk seen: validation always rejects
          default: res = '{valid: 1'b1, item: make_fail(ST_REJECT)};
        endcase
        // rearm for the next file
        phase_nxt   = PH_RIFF;
        offset_nxt  = '0;
        count_nxt   = '0;
        shift_nxt   = '0;
        skip_nxt    = '0;
        fmt_nxt     = '0;
        chans_nxt   = '0;
        rate_nxt    = '0;
        bits_nxt    = '0;
        riff_ok_nxt = 1'b1;
      end else if (phase_r != PH_DONE) begin
        offset_nxt = offset_r + 32'd1;
        case (phase_r)
          PH_RIFF: begin
            if ((count_r < 4'd4 || count_r >= 4'd8) && b != riff_expect(count_r)) begin
              riff_ok_nxt = 1'b0;
            end
            count_nxt = count_r + 4'd1;
            if (count_r == 4'd11) begin
              count_nxt = '0;
              if (!riff_ok_nxt) begin
                phase_nxt = PH_DONE;
                res       = '{valid: 1'b1, item: make_fail(ST_BAD_HDR)};
              end else begin
                phase_nxt = PH_CHUNK;
              end
            end
          end
          PH_CHUNK: begin
            shift_nxt = shift_in;
            count_nxt = count_r + 4'd1;
            if (count_r == 4'd7) begin
              count_nxt = '0;
              if (shift_in[31:0] == ID_FMT) begin
                if (hdr_len < FMT_MIN_LEN) begin
                  phase_nxt = PH_DONE;
                  res       = '{valid: 1'b1, item: make_fail(ST_BAD_FMT)};
                end else begin
                  phase_nxt = PH_FMT;
                end
              end else if (shift_in[31:0] == ID_DATA) begin
                phase_nxt = PH_DONE;
                res       = '{valid: 1'b1, item: make_final(fmt_r, chans_r, rate_r, bits_r,
                                                          file_length, offset_nxt, hdr_len)};
              end else begin
                skip_nxt  = chunk_skip;
                phase_nxt = (chunk_skip != 33'd0) ? PH_SKIP : PH_CHUNK;
              end
            end
          end
          PH_FMT: begin
            case (count_r)
              4'd0:    fmt_nxt   = {8'h00, b};
              4'd1:    fmt_nxt   = {b, fmt_r[7:0]};
              4'd2:    chans_nxt = {8'h00, b};
              4'd3:    chans_nxt = {b, chans_r[7:0]};
              4'd4:    rate_nxt  = {24'h000000, b};
              4'd5:    rate_nxt  = {rate_r[31:16], b, rate_r[7:0]};
              4'd6:    rate_nxt  = {rate_r[31:24], b, rate_r[15:0]};
              4'd7:    rate_nxt  = {b, rate_r[23:0]};
              4'd14:   bits_nxt  = {8'h00, b};
              4'd15:   bits_nxt  = {b, bits_r[7:0]};
              default: fmt_nxt   = fmt_r;
            endcase
            count_nxt = count_r + 4'd1;
            if (count_r == 4'd15) begin
              count_nxt = '0;
              skip_nxt  = fmt_skip;
              phase_nxt = (fmt_skip != 33'd0) ? PH_SKIP : PH_CHUNK;
            end
          end
          default: begin
            skip_nxt = skip_dec;
            if (skip_dec == 33'd0) begin
              phase_nxt = PH_CHUNK;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_RIFF;
      offset_r  <= '0;
      count_r   <= '0;
      shift_r   <= '0;
      skip_r    <= '0;
      fmt_r     <= '0;
      chans_r   <= '0;
      rate_r    <= '0;
      bits_r    <= '0;
      riff_ok_r <= 1'b1;
    end else begin
      phase_r   <= phase_nxt;
      offset_r  <= offset_nxt;
      count_r   <= count_nxt;
      shift_r   <= shift_nxt;
      skip_r    <= skip_nxt;
      fmt_r     <= fmt_nxt;
      chans_r   <= chans_nxt;
      rate_r    <= rate_nxt;
      bits_r    <= bits_nxt;
      riff_ok_r <= riff_ok_nxt;
    end
  end

endmodule

[rtl/wav_hdr_outq.sv]
module wav_hdr_outq (
  input  logic                   clk,
  input  logic                   rst_n,
  input  wav_hdr_pkg::res_push_t res,
  output logic                   full,
  output logic                   out_valid,
  input  logic                   out_stall,
  output wav_hdr_pkg::out_item_t out_item
);
  import wav_hdr_pkg::*;

  logic      main_v_r, main_v_nxt;
  logic      skid_v_r, skid_v_nxt;
  out_item_t main_r,   main_nxt;
  out_item_t skid_r,   skid_nxt;
  logic      pop;

  assign pop       = main_v_r && !out_stall;
  assign full      = skid_v_r;
  assign out_valid = main_v_r;
  assign out_item  = main_r;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (skid_v_r) begin
      // input is held off while the skid is full
      if (pop) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (res.valid) begin
      if (main_v_r && !pop) begin
        skid_nxt   = res.item;
        skid_v_nxt = 1'b1;
      end else begin
        main_nxt   = res.item;
        main_v_nxt = 1'b1;
      end
    end else if (pop) begin
      main_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule
